// File: design/assert_macros.svh
// assertion macros shared by the job region table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define JRT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define JRT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define JRT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define JRT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: design/jrt_pkg.sv
// shared types and constants of the job region table
`timescale 1ns / 1ps
`default_nettype none

package jrt_pkg;

   localparam int JRT_JOB_SLOTS   = 16;
   localparam int JRT_MEM_UNITS   = 1024;
   localparam int JRT_PRIO_LEVELS = 4;
   localparam int JRT_CMD_DEPTH   = 2;

   // saturation limits of stored size and priority
   localparam logic [10:0] SIZE_MAX = 11'(JRT_MEM_UNITS);
   localparam logic [1:0]  PRIO_MAX = 2'(JRT_PRIO_LEVELS - 1);

   typedef enum logic [1:0] {
      OP_REGISTER   = 2'd0,
      OP_UNREGISTER = 2'd1,
      OP_OWNER      = 2'd2,
      OP_EVICT      = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SCAN,
      ST_DRAIN,
      ST_REPLY
   } back_state_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  job_id;
      logic [9:0]  start_unit;
      logic [10:0] size_units;
      logic [1:0]  priority_req;
      logic [15:0] remaining_ticks;
      logic [9:0]  query_unit;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  found_job_id;
      logic [9:0]  found_start;
      logic [10:0] found_size;
      logic [1:0]  found_priority;
      logic [15:0] found_ticks;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      op_type      op;
      logic        id_ok;
      logic [3:0]  job_id;
      logic [9:0]  start_unit;
      logic [10:0] size_units;
      logic [1:0]  priority_req;
      logic [15:0] remaining_ticks;
      logic [9:0]  query_unit;
      logic [10:0] req_end;
   } cmd_type;

   typedef struct packed {
      logic        full;
      logic        empty;
   } fifo_status_type;

   typedef struct packed {
      logic [9:0]  start;
      logic [10:0] size;
      logic [1:0]  prio;
      logic [15:0] ticks;
   } slot_type;

endpackage

`default_nettype wire

// File: design/jrt_front.sv
// front end: accepts items, saturates fields and queues commands
`timescale 1ns / 1ps
`default_nettype none

module jrt_front #(
   parameter int JOB_SLOTS = jrt_pkg::JRT_JOB_SLOTS
) (
   input  wire                      start,
   input  jrt_pkg::req_type         req_item,
   input  jrt_pkg::fifo_status_type fifo_status,
   output logic                     busy,
   output logic                     push,
   output jrt_pkg::cmd_type         push_cmd
);
   import jrt_pkg::*;

   // accept while the command queue has room
   assign busy = fifo_status.full;
   assign push = start & ~fifo_status.full;

   // classify and saturate the item
   always_comb begin
      push_cmd.op              = req_item.op;
      push_cmd.id_ok           = int'(req_item.job_id) < JOB_SLOTS;
      push_cmd.job_id          = req_item.job_id;
      push_cmd.start_unit      = req_item.start_unit;
      push_cmd.size_units      = (req_item.size_units > SIZE_MAX) ? SIZE_MAX
                                                                  : req_item.size_units;
      push_cmd.priority_req    = (req_item.priority_req > PRIO_MAX) ? PRIO_MAX
                                                                    : req_item.priority_req;
      push_cmd.remaining_ticks = req_item.remaining_ticks;
      push_cmd.query_unit      = req_item.query_unit;
      push_cmd.req_end         = {1'b0, req_item.start_unit} + push_cmd.size_units;
   end

endmodule

`default_nettype wire

// File: design/jrt_cmd_fifo.sv
// short command queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module jrt_cmd_fifo (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  jrt_pkg::cmd_type         push_cmd,
   input  wire                      pop,
   output jrt_pkg::cmd_type         head_cmd,
   output jrt_pkg::fifo_status_type fifo_status
);
   import jrt_pkg::*;

   localparam int PTR_W = (JRT_CMD_DEPTH > 1) ? $clog2(JRT_CMD_DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(JRT_CMD_DEPTH - 1);
   localparam logic [PTR_W:0]   FULL_CNT = (PTR_W + 1)'(JRT_CMD_DEPTH);

   cmd_type          q_ff [JRT_CMD_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + (PTR_W + 1)'(1);
         2'b01:   count_in = count_ff - (PTR_W + 1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd          = q_ff[rd_ptr_ff];
   assign fifo_status.full  = (count_ff == FULL_CNT);
   assign fifo_status.empty = (count_ff == '0);

endmodule

`default_nettype wire

// File: design/jrt_back.sv
// back end: slot table, update and one-slot-per-cycle search
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module jrt_back #(
   parameter int JOB_SLOTS = jrt_pkg::JRT_JOB_SLOTS
) (
   input  wire                      clock,
   input  wire                      reset,
   input  jrt_pkg::fifo_status_type fifo_status,
   input  jrt_pkg::cmd_type         head_cmd,
   output logic                     pop,
   output logic                     rsp_valid,
   output jrt_pkg::rsp_type         rsp_item
);
   import jrt_pkg::*;

   localparam int SLOT_W = $clog2(JOB_SLOTS);
   localparam int IDX_W  = (SLOT_W > 4) ? SLOT_W : 4;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(JOB_SLOTS - 1);

   back_state_type      state_ff, state_in;
   cmd_type             cur_ff, cur_in;
   logic [SLOT_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [JOB_SLOTS-1:0] valid_ff, valid_in;
   slot_type            slot_mem [JOB_SLOTS];
   logic                mem_we;
   slot_type            wr_slot;
   logic [IDX_W-1:0]    id_ext;
   logic [SLOT_W-1:0]   wr_idx;

   slot_type            cand_slot_ff;
   logic                cand_valid_ff;
   logic [SLOT_W-1:0]   cand_idx_ff;
   logic                cand_live_ff, cand_live_in;

   logic                have_ff, have_in;
   logic [SLOT_W-1:0]   best_idx_ff, best_idx_in;
   slot_type            best_slot_ff, best_slot_in;
   logic [IDX_W-1:0]    best_ext;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [10:0]         cand_end;
   logic                owner_hit, adjacent, is_self, better, take;

   // slot index of the command
   assign id_ext = IDX_W'(cur_ff.job_id);
   assign wr_idx = id_ext[SLOT_W-1:0];

   assign wr_slot.start = cur_ff.start_unit;
   assign wr_slot.size  = cur_ff.size_units;
   assign wr_slot.prio  = cur_ff.priority_req;
   assign wr_slot.ticks = cur_ff.remaining_ticks;

   // candidate compare on the registered read
   always_comb begin
      cand_end  = {1'b0, cand_slot_ff.start} + cand_slot_ff.size;
      owner_hit = (cur_ff.query_unit >= cand_slot_ff.start) &&
                  ({1'b0, cur_ff.query_unit} < cand_end);
      adjacent  = (cand_end == {1'b0, cur_ff.start_unit}) ||
                  ({1'b0, cand_slot_ff.start} == cur_ff.req_end);
      is_self   = cur_ff.id_ok && (cand_idx_ff == wr_idx);
      better    = !have_ff || (cand_slot_ff.prio < best_slot_ff.prio) ||
                  ((cand_slot_ff.prio == best_slot_ff.prio) &&
                   (cand_slot_ff.ticks < best_slot_ff.ticks));
      take      = 1'b0;
      if (cand_live_ff && cand_valid_ff) begin
         if (cur_ff.op == OP_OWNER) begin
            take = owner_hit && !have_ff;
         end else begin
            take = adjacent && !is_self && better;
         end
      end
   end

   assign cand_live_in = (state_ff == ST_SCAN);
   assign best_ext     = IDX_W'(best_idx_ff);

   // sequencer next state and outputs
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      scan_idx_in  = scan_idx_ff;
      valid_in     = valid_ff;
      have_in      = have_ff;
      best_idx_in  = best_idx_ff;
      best_slot_in = best_slot_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;

      if (take) begin
         have_in      = 1'b1;
         best_idx_in  = cand_idx_ff;
         best_slot_in = cand_slot_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!fifo_status.empty) begin
               pop         = 1'b1;
               cur_in      = head_cmd;
               scan_idx_in = '0;
               have_in     = 1'b0;
               case (head_cmd.op) inside
                  OP_OWNER, OP_EVICT: state_in = ST_SCAN;
                  default:            state_in = ST_UPDATE;
               endcase
            end
         end
         ST_UPDATE: begin
            if (cur_ff.id_ok) begin
               if (cur_ff.op == OP_REGISTER) begin
                  mem_we           = 1'b1;
                  valid_in[wr_idx] = 1'b1;
               end else begin
                  valid_in[wr_idx] = 1'b0;
               end
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SCAN: begin
            if (scan_idx_ff == LAST_SLOT) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + SLOT_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            rsp_valid_in = 1'b1;
            if (have_ff) begin
               rsp_in.found          = 1'b1;
               rsp_in.found_job_id   = best_ext[3:0];
               rsp_in.found_start    = best_slot_ff.start;
               rsp_in.found_size     = best_slot_ff.size;
               rsp_in.found_priority = best_slot_ff.prio;
               rsp_in.found_ticks    = best_slot_ff.ticks;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         have_ff      <= 1'b0;
         cand_live_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         have_ff      <= have_in;
         cand_live_ff <= cand_live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      scan_idx_ff   <= scan_idx_in;
      best_idx_ff   <= best_idx_in;
      best_slot_ff  <= best_slot_in;
      rsp_ff        <= rsp_in;
      cand_idx_ff   <= scan_idx_ff;
      cand_valid_ff <= valid_ff[scan_idx_ff];
   end

   // slot memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[wr_idx] <= wr_slot;
      end
      cand_slot_ff <= slot_mem[scan_idx_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // checks
   `JRT_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid_ff, !rsp_valid_ff, "result strobe longer than one cycle")
   `JRT_ASSERT_IMPL(a_best_is_valid, clock, reset, have_ff, valid_ff[best_idx_ff], "chosen slot is not valid")
   `JRT_ASSERT_NEXT(a_pop_starts_work, clock, reset, pop, (state_ff == ST_SCAN || state_ff == ST_UPDATE), "popped item not started")
   `JRT_ASSERT_IMPL(a_found_from_best, clock, reset, (rsp_valid_ff && rsp_ff.found), have_ff, "found without a chosen slot")

endmodule

`default_nettype wire

// File: design/job_region_table_evict_select_core.sv
// top level of the job region table with owner lookup and eviction search
`timescale 1ns / 1ps
`default_nettype none

// An item is taken on a clock edge with start high and busy low; a two-item command
// queue sits behind the port, so busy rises only when that queue is full. Register and
// unregister items pass through the update state of the back end. Owner lookup and
// eviction search walk the slot table one slot per clock through the registered read
// port of the slot memory, then pass through the drain and reply states. Every
// item gives exactly one result, in order: rsp_valid is high for one cycle with the
// result on rsp_item, and the receiver must take it then, as it cannot stall the block.
module job_region_table_evict_select_core #(
   parameter int JOB_SLOTS = jrt_pkg::JRT_JOB_SLOTS
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  jrt_pkg::req_type  req_item,
   output logic              rsp_valid,
   output jrt_pkg::rsp_type  rsp_item
);
   import jrt_pkg::*;

   fifo_status_type fifo_status;
   cmd_type         push_cmd;
   cmd_type         head_cmd;
   logic            push;
   logic            pop;

   // accept and classify
   jrt_front #(
      .JOB_SLOTS (JOB_SLOTS)
   ) u_front (
      .start       (start),
      .req_item    (req_item),
      .fifo_status (fifo_status),
      .busy        (busy),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // command queue
   jrt_cmd_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_cmd    (push_cmd),
      .pop         (pop),
      .head_cmd    (head_cmd),
      .fifo_status (fifo_status)
   );

   // table and search
   jrt_back #(
      .JOB_SLOTS (JOB_SLOTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_status (fifo_status),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item)
   );

endmodule

`default_nettype wire

// File: bench/testbench.sv
// self-checking bench for the job region table: lookup, eviction search and slot updates
`timescale 1ns / 1ps

module testbench;
   import jrt_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_PER_PHASE = 350;

   // one queued item with its pacing
   typedef struct {
      req_type item;
      int      idle_pct;
      bit      drain_first;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   pending_type item_q[$];
   rsp_type     answer_q[$];

   // mirror of the slot table
   bit       tbl_valid [JRT_JOB_SLOTS];
   slot_type tbl_slot  [JRT_JOB_SLOTS];

   // shadow used only to shape stimulus
   bit gen_live  [JRT_JOB_SLOTS];
   int gen_start [JRT_JOB_SLOTS];
   int gen_size  [JRT_JOB_SLOTS];

   int n_accepted = 0;
   int results_seen = 0;
   int fail_count = 0;
   int cycle_count = 0;
   int op_count [4];
   int hit_count [4];

   job_region_table_evict_select_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // clock and reset
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // apply one item to the mirrored table and give the answer it produces
   function automatic rsp_type table_step(req_type r);
      rsp_type    ans;
      logic [10:0] sz;
      logic [1:0]  pr;
      bit          id_ok;
      bit          have;
      int          best;
      int          req_end;
      int          slot_end;
      ans = '0;
      sz = (r.size_units > SIZE_MAX) ? SIZE_MAX : r.size_units;
      pr = (int'(r.priority_req) >= JRT_PRIO_LEVELS) ? PRIO_MAX : r.priority_req;
      id_ok = int'(r.job_id) < JRT_JOB_SLOTS;
      have = 1'b0;
      best = 0;
      case (r.op)
         OP_REGISTER: begin
            if (id_ok) begin
               tbl_valid[r.job_id] = 1'b1;
               tbl_slot[r.job_id].start = r.start_unit;
               tbl_slot[r.job_id].size = sz;
               tbl_slot[r.job_id].prio = pr;
               tbl_slot[r.job_id].ticks = r.remaining_ticks;
            end
         end
         OP_UNREGISTER: begin
            if (id_ok) tbl_valid[r.job_id] = 1'b0;
         end
         OP_OWNER: begin
            // first valid slot containing the unit
            for (int k = 0; k < JRT_JOB_SLOTS; k++) begin
               if (!have && tbl_valid[k] && int'(r.query_unit) >= int'(tbl_slot[k].start) &&
                   int'(r.query_unit) < int'(tbl_slot[k].start) + int'(tbl_slot[k].size)) begin
                  have = 1'b1;
                  best = k;
               end
            end
         end
         default: begin
            // neighbors touching the requester, lowest priority then fewest ticks
            req_end = int'(r.start_unit) + int'(sz);
            for (int k = 0; k < JRT_JOB_SLOTS; k++) begin
               slot_end = int'(tbl_slot[k].start) + int'(tbl_slot[k].size);
               if (tbl_valid[k] && !(id_ok && k == int'(r.job_id)) &&
                   (slot_end == int'(r.start_unit) || int'(tbl_slot[k].start) == req_end)) begin
                  if (!have || tbl_slot[k].prio < tbl_slot[best].prio ||
                      (tbl_slot[k].prio == tbl_slot[best].prio &&
                       tbl_slot[k].ticks < tbl_slot[best].ticks)) begin
                     have = 1'b1;
                     best = k;
                  end
               end
            end
         end
      endcase
      if (have) begin
         ans.found = 1'b1;
         ans.found_job_id = 4'(best);
         ans.found_start = tbl_slot[best].start;
         ans.found_size = tbl_slot[best].size;
         ans.found_priority = tbl_slot[best].prio;
         ans.found_ticks = tbl_slot[best].ticks;
      end
      return ans;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // queue one item and track the table shape for later items
   task automatic add_item(op_type op, int id, int st, int sz, int pr, int tk, int q,
                           int idle_pct, bit drain);
      pending_type p;
      p.item.op = op;
      p.item.job_id = 4'(id);
      p.item.start_unit = 10'(st);
      p.item.size_units = 11'(sz);
      p.item.priority_req = 2'(pr);
      p.item.remaining_ticks = 16'(tk);
      p.item.query_unit = 10'(q);
      p.idle_pct = idle_pct;
      p.drain_first = drain;
      item_q.push_back(p);
      if (op == OP_REGISTER) begin
         gen_live[id % JRT_JOB_SLOTS] = 1'b1;
         gen_start[id % JRT_JOB_SLOTS] = st % 1024;
         gen_size[id % JRT_JOB_SLOTS] = ((sz % 2048) > JRT_MEM_UNITS) ? JRT_MEM_UNITS : sz % 2048;
      end else if (op == OP_UNREGISTER) begin
         gen_live[id % JRT_JOB_SLOTS] = 1'b0;
      end
   endtask

   // region sizes: mostly grid multiples, with zero, full and saturating sizes
   function automatic int shaped_size();
      int c;
      c = $urandom_range(99);
      if (c < 10) return 0;
      if (c < 20) return $urandom_range(2047, 1025);
      if (c < 25) return JRT_MEM_UNITS;
      if (c < 70) return 64 * $urandom_range(4, 1);
      return $urandom_range(1023, 1);
   endfunction

   // one random item, biased toward regions that touch registered ones
   task automatic add_random(int idle_pct, bit drain);
      int sel, id, st, sz, pr, tk, q, pick, slot_end;
      id = $urandom_range(15);
      st = $urandom_range(1023);
      sz = $urandom_range(2047);
      pr = $urandom_range(3);
      tk = $urandom_range(65535);
      q = $urandom_range(1023);
      pick = -1;
      for (int t = 0; t < 8 && pick < 0; t++) begin
         id = $urandom_range(15);
         if (gen_live[id]) pick = id;
      end
      id = $urandom_range(15);
      sel = $urandom_range(99);
      if (sel < 15) begin
         add_item(op_type'($urandom_range(3)), id, st, sz, pr, tk, q, idle_pct, drain);
      end else if (sel < 45) begin
         if ($urandom_range(99) < 60) st = 64 * $urandom_range(15);
         sz = shaped_size();
         if ($urandom_range(99) < 40) tk = $urandom_range(3);
         add_item(OP_REGISTER, id, st, sz, pr, tk, q, idle_pct, drain);
      end else if (sel < 55) begin
         add_item(OP_UNREGISTER, id, st, sz, pr, tk, q, idle_pct, drain);
      end else if (sel < 75) begin
         if (pick >= 0 && gen_size[pick] > 0 && $urandom_range(3) != 0) begin
            q = gen_start[pick] + $urandom_range(gen_size[pick] - 1);
            if (q > 1023) q = $urandom_range(1023);
         end
         add_item(OP_OWNER, id, st, sz, pr, tk, q, idle_pct, drain);
      end else begin
         if (pick >= 0 && $urandom_range(9) < 7) begin
            slot_end = gen_start[pick] + gen_size[pick];
            sz = shaped_size();
            if (sz > JRT_MEM_UNITS) sz = JRT_MEM_UNITS;
            if ($urandom_range(1) == 0 && slot_end <= 1023) begin
               st = slot_end;
            end else begin
               st = gen_start[pick] - sz;
               if (st < 0) begin
                  sz = gen_start[pick];
                  st = 0;
               end
            end
         end
         add_item(OP_EVICT, id, st, sz, pr, tk, q, idle_pct, drain);
      end
   endtask

   // stimulus and end of run
   initial begin
      for (int k = 0; k < JRT_JOB_SLOTS; k++) begin
         tbl_valid[k] = 1'b0;
         tbl_slot[k] = '0;
         gen_live[k] = 1'b0;
         gen_start[k] = 0;
         gen_size[k] = 0;
      end
      for (int k = 0; k < 4; k++) begin
         op_count[k] = 0;
         hit_count[k] = 0;
      end

      // directed: empty table, extremes, boundaries and tie breaks
      add_item(OP_OWNER, 0, 0, 0, 0, 0, 0, 0, 0);
      add_item(OP_EVICT, 0, 0, 0, 0, 0, 0, 0, 0);
      add_item(OP_UNREGISTER, 7, 1023, 2047, 3, 65535, 1023, 0, 0);
      add_item(OP_REGISTER, 0, 0, 64, 2, 100, 0, 0, 0);
      add_item(OP_REGISTER, 1, 64, 64, 1, 65535, 0, 0, 0);
      add_item(OP_REGISTER, 2, 128, 0, 0, 0, 0, 0, 0);
      add_item(OP_REGISTER, 15, 1023, 2047, 3, 65535, 1023, 0, 0);
      add_item(OP_REGISTER, 3, 192, 1024, 3, 5, 0, 0, 0);
      add_item(OP_OWNER, 0, 0, 0, 0, 0, 0, 0, 0);
      add_item(OP_OWNER, 0, 0, 0, 0, 0, 64, 0, 0);
      add_item(OP_OWNER, 0, 0, 0, 0, 0, 128, 0, 0);
      add_item(OP_OWNER, 0, 0, 0, 0, 0, 1023, 0, 0);
      add_item(OP_EVICT, 1, 64, 64, 0, 0, 0, 0, 0);
      add_item(OP_EVICT, 2, 64, 64, 0, 0, 0, 0, 0);
      add_item(OP_REGISTER, 4, 256, 64, 1, 7, 0, 0, 0);
      add_item(OP_REGISTER, 5, 384, 64, 1, 7, 0, 0, 0);
      add_item(OP_EVICT, 9, 320, 64, 0, 0, 0, 0, 0);
      add_item(OP_REGISTER, 5, 384, 64, 1, 6, 0, 0, 0);
      add_item(OP_EVICT, 9, 320, 64, 0, 0, 0, 0, 0);
      add_item(OP_UNREGISTER, 5, 0, 0, 0, 0, 0, 0, 0);
      add_item(OP_EVICT, 9, 320, 64, 3, 65535, 0, 0, 0);
      add_item(OP_EVICT, 0, 1023, 0, 0, 0, 0, 0, 0);
      add_item(OP_EVICT, 15, 1023, 0, 0, 0, 0, 0, 0);
      add_item(OP_UNREGISTER, 3, 0, 0, 0, 0, 0, 0, 0);
      add_item(OP_OWNER, 0, 0, 0, 0, 0, 1023, 0, 0);

      // random: sender idles often, then very often, then never
      for (int i = 0; i < RANDOM_PER_PHASE; i++) add_random(38, i == 0);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) add_random(78, i == 0);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) add_random(0, i == 0 || i == 200);

      // wait for all items taken, all answers back, then a trailing window
      @(negedge clock);
      while (item_q.size() != 0 || start) @(negedge clock);
      while (answer_q.size() != 0) @(negedge clock);
      repeat (JRT_JOB_SLOTS + 12) @(negedge clock);

      $display("covered %0d items: %0d register, %0d unregister", n_accepted,
               op_count[OP_REGISTER], op_count[OP_UNREGISTER]);
      $display("owner lookups %0d (%0d found), eviction searches %0d (%0d found)",
               op_count[OP_OWNER], hit_count[OP_OWNER], op_count[OP_EVICT], hit_count[OP_EVICT]);
      if (fail_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // driver: take acceptance, predict, present the next item or idle
   always @(posedge clock) begin
      int      outstanding;
      rsp_type ans;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            ans = table_step(req_item);
            answer_q.push_back(ans);
            n_accepted++;
            op_count[req_item.op]++;
            if (ans.found) hit_count[req_item.op]++;
         end
         // results_seen is updated nonblocking, so this is the pre-edge count
         outstanding = n_accepted - results_seen - (rsp_valid ? 1 : 0);
         if (item_q.size() != 0 && (!item_q[0].drain_first || outstanding <= 0) &&
             $urandom_range(99) >= item_q[0].idle_pct) begin
            req_item <= item_q[0].item;
            start <= 1'b1;
            void'(item_q.pop_front());
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: compare each strobed result with the oldest answer
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (answer_q.size() == 0) begin
            $error("result with no item waiting: %p", rsp_item);
            fail_count++;
         end else begin
            want = answer_q.pop_front();
            check_field("found", want.found, rsp_item.found);
            check_field("found_job_id", want.found_job_id, rsp_item.found_job_id);
            check_field("found_start", want.found_start, rsp_item.found_start);
            check_field("found_size", want.found_size, rsp_item.found_size);
            check_field("found_priority", want.found_priority, rsp_item.found_priority);
            check_field("found_ticks", want.found_ticks, rsp_item.found_ticks);
         end
         results_seen <= results_seen + 1;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

endmodule

// File: sim.f
+incdir+design
design/jrt_pkg.sv
design/jrt_front.sv
design/jrt_cmd_fifo.sv
design/jrt_back.sv
design/job_region_table_evict_select_core.sv
bench/testbench.sv
